FILE: rtl/core/tun_pkg.sv
package tun_pkg;

  localparam int CoordWidth = 16;
  localparam int FracBits = 14;
  localparam int OutWidth = 16;

  // Edge components carry one bit more than a coordinate.
  localparam int EdgeWidth = CoordWidth + 1;
  // One cross product term and the difference of two of them.
  localparam int ProdWidth = 2 * EdgeWidth;
  localparam int CrossWidth = ProdWidth + 1;
  localparam int MagWidth = CrossWidth;
  localparam int BlWidth = $clog2(MagWidth + 1);

  // Magnitudes normalized to a bit length of 31.
  localparam int NormBits = 31;
  localparam int SumWidth = 2 * NormBits + 2;
  localparam int LenWidth = 32;
  localparam int DivWidth = NormBits + FracBits;
  localparam int QWidth = DivWidth + 1;

endpackage

FILE: rtl/core/triangle_unit_normal_top.sv
// Pipeline depth: 1 + 1 + 1 + 1 + 1 + 32 + 1 + 46 + 1 = 85 register stages from start to done.
// Throughput: one triangle per clock cycle; busy is never raised.
// The square root takes one result bit per stage and the divider one quotient bit per stage,
// so the pipeline depth is set by those two iterations.
// Reset (rst, synchronous) clears every valid bit; payload registers are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle with done high.
module triangle_unit_normal_top
  import tun_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [CoordWidth-1:0] p1_x,
  input  logic signed [CoordWidth-1:0] p1_y,
  input  logic signed [CoordWidth-1:0] p1_z,
  input  logic signed [CoordWidth-1:0] p2_x,
  input  logic signed [CoordWidth-1:0] p2_y,
  input  logic signed [CoordWidth-1:0] p2_z,
  input  logic signed [CoordWidth-1:0] p3_x,
  input  logic signed [CoordWidth-1:0] p3_y,
  input  logic signed [CoordWidth-1:0] p3_z,
  output logic                         done,
  output logic signed [OutWidth-1:0]   normal_x,
  output logic signed [OutWidth-1:0]   normal_y,
  output logic signed [OutWidth-1:0]   normal_z,
  output logic                         degenerate
);

  localparam int SqSteps = LenWidth;
  localparam int DivSteps = DivWidth;

  // The pipeline never stalls, since the receiver cannot hold results off.
  assign busy = 1'b0;

  // Stage 1: edge vectors.
  logic                        s1_v;
  logic signed [EdgeWidth-1:0] ea [3];
  logic signed [EdgeWidth-1:0] eb [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= start;
    end
    ea[0] <= EdgeWidth'(p2_x) - EdgeWidth'(p1_x);
    ea[1] <= EdgeWidth'(p2_y) - EdgeWidth'(p1_y);
    ea[2] <= EdgeWidth'(p2_z) - EdgeWidth'(p1_z);
    eb[0] <= EdgeWidth'(p3_x) - EdgeWidth'(p1_x);
    eb[1] <= EdgeWidth'(p3_y) - EdgeWidth'(p1_y);
    eb[2] <= EdgeWidth'(p3_z) - EdgeWidth'(p1_z);
  end

  // Stage 2: the six cross product terms, one multiplier each.
  logic                        s2_v;
  logic signed [ProdWidth-1:0] pp [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    pp[0] <= ea[1] * eb[2];
    pp[1] <= ea[2] * eb[1];
    pp[2] <= ea[2] * eb[0];
    pp[3] <= ea[0] * eb[2];
    pp[4] <= ea[0] * eb[1];
    pp[5] <= ea[1] * eb[0];
  end

  // Stage 3: cross product, split into sign and magnitude.
  logic                         s3_v;
  logic [2:0]                   s3_neg;
  logic [MagWidth-1:0]          s3_mag [3];
  logic signed [CrossWidth-1:0] cr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i] = CrossWidth'(pp[2*i]) - CrossWidth'(pp[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else begin
      s3_v <= s2_v;
    end
    for (int i = 0; i < 3; i++) begin
      s3_neg[i] <= cr[i][CrossWidth-1];
      s3_mag[i] <= cr[i][CrossWidth-1] ? MagWidth'(-cr[i]) : MagWidth'(cr[i]);
    end
  end

  // Stage 4: normalize so the largest magnitude has a bit length of 31.
  logic [MagWidth-1:0] orm;
  logic [BlWidth-1:0]  bl;
  logic                s4_v;
  logic                s4_deg;
  logic [2:0]          s4_neg;
  logic [NormBits-1:0] s4_mag [3];

  always_comb begin
    orm = s3_mag[0] | s3_mag[1] | s3_mag[2];
    bl = '0;
    for (int k = 0; k < MagWidth; k++) begin
      if (orm[k]) begin
        bl = BlWidth'(k + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else begin
      s4_v <= s3_v;
    end
    s4_deg <= (orm == '0);
    s4_neg <= s3_neg;
    for (int i = 0; i < 3; i++) begin
      if (bl > BlWidth'(NormBits)) begin
        s4_mag[i] <= NormBits'(s3_mag[i] >> (bl - BlWidth'(NormBits)));
      end else begin
        s4_mag[i] <= NormBits'(s3_mag[i] << (BlWidth'(NormBits) - bl));
      end
    end
  end

  // Stage 5: sum of squares.
  logic                s5_v;
  logic                s5_deg;
  logic [2:0]          s5_neg;
  logic [NormBits-1:0] s5_mag [3];
  logic [SumWidth-1:0] sq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else begin
      s5_v <= s4_v;
    end
    s5_deg <= s4_deg;
    s5_neg <= s4_neg;
    s5_mag <= s4_mag;
    for (int i = 0; i < 3; i++) begin
      sq[i] <= SumWidth'(s4_mag[i]) * SumWidth'(s4_mag[i]);
    end
  end

  // Square root pipeline: one result bit per stage, restoring method.
  logic                sr_v   [SqSteps+1];
  logic                sr_deg [SqSteps+1];
  logic [2:0]          sr_neg [SqSteps+1];
  logic [NormBits-1:0] sr_mag [SqSteps+1][3];
  logic [SumWidth-1:0] sr_rem [SqSteps+1];
  logic [LenWidth-1:0] sr_root [SqSteps+1];

  always_comb begin
    sr_v[0] = s5_v;
    sr_deg[0] = s5_deg;
    sr_neg[0] = s5_neg;
    sr_mag[0] = s5_mag;
    sr_rem[0] = sq[0] + sq[1] + sq[2];
    sr_root[0] = '0;
  end

  for (genvar g = 0; g < SqSteps; g++) begin : g_sqrt
    localparam int B = SqSteps - 1 - g;
    logic [SumWidth+1:0] trial;
    logic [SumWidth+1:0] rem_w;
    always_comb begin
      trial = ((SumWidth + 2)'(sr_root[g]) << (B + 1)) | ((SumWidth + 2)'(1) << (2 * B));
      rem_w = (SumWidth + 2)'(sr_rem[g]);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sr_v[g+1] <= 1'b0;
      end else begin
        sr_v[g+1] <= sr_v[g];
      end
      sr_deg[g+1] <= sr_deg[g];
      sr_neg[g+1] <= sr_neg[g];
      sr_mag[g+1] <= sr_mag[g];
      if (rem_w >= trial) begin
        sr_rem[g+1] <= SumWidth'(rem_w - trial);
        sr_root[g+1] <= sr_root[g] | (LenWidth'(1) << B);
      end else begin
        sr_rem[g+1] <= sr_rem[g];
        sr_root[g+1] <= sr_root[g];
      end
    end
  end

  // Rounded dividends: |N| * 2^FracBits + len/2.
  logic                dv_v;
  logic                dv_deg;
  logic [2:0]          dv_neg;
  logic [LenWidth-1:0] dv_len;
  logic [QWidth-1:0]   dv_num [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v <= 1'b0;
    end else begin
      dv_v <= sr_v[SqSteps];
    end
    dv_deg <= sr_deg[SqSteps];
    dv_neg <= sr_neg[SqSteps];
    dv_len <= sr_root[SqSteps];
    for (int i = 0; i < 3; i++) begin
      dv_num[i] <= (QWidth'(sr_mag[SqSteps][i]) << FracBits)
                   + QWidth'(sr_root[SqSteps] >> 1);
    end
  end

  // Divider pipeline: three restoring dividers sharing the stages, one quotient bit each.
  localparam int RemWidth = LenWidth + 1;
  logic                dd_v   [DivSteps+2];
  logic                dd_deg [DivSteps+2];
  logic [2:0]          dd_neg [DivSteps+2];
  logic [LenWidth-1:0] dd_len [DivSteps+2];
  logic [QWidth-1:0]   dd_num [DivSteps+2][3];
  logic [QWidth-1:0]   dd_q   [DivSteps+2][3];
  logic [RemWidth-1:0] dd_rem [DivSteps+2][3];

  always_comb begin
    dd_v[0] = dv_v;
    dd_deg[0] = dv_deg;
    dd_neg[0] = dv_neg;
    dd_len[0] = dv_len;
    dd_num[0] = dv_num;
    for (int i = 0; i < 3; i++) begin
      dd_q[0][i] = '0;
      dd_rem[0][i] = '0;
    end
  end

  for (genvar g = 0; g < DivSteps + 1; g++) begin : g_div
    localparam int B = QWidth - 1 - g;
    logic [RemWidth-1:0] sh [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        sh[i] = {dd_rem[g][i][RemWidth-2:0], dd_num[g][i][B]};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dd_v[g+1] <= 1'b0;
      end else begin
        dd_v[g+1] <= dd_v[g];
      end
      dd_deg[g+1] <= dd_deg[g];
      dd_neg[g+1] <= dd_neg[g];
      dd_len[g+1] <= dd_len[g];
      dd_num[g+1] <= dd_num[g];
      for (int i = 0; i < 3; i++) begin
        if (sh[i] >= RemWidth'(dd_len[g])) begin
          dd_rem[g+1][i] <= sh[i] - RemWidth'(dd_len[g]);
          dd_q[g+1][i] <= dd_q[g][i] | (QWidth'(1) << B);
        end else begin
          dd_rem[g+1][i] <= sh[i];
          dd_q[g+1][i] <= dd_q[g][i];
        end
      end
    end
  end

  // Output stage: saturate, apply sign, force zero on a degenerate triangle.
  localparam int Last = DivSteps + 1;
  localparam logic [QWidth-1:0] Limit = QWidth'(1) << FracBits;
  logic [QWidth-1:0] qs [3];
  logic [OutWidth-1:0] res [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = (dd_q[Last][i] > Limit) ? Limit : dd_q[Last][i];
      if (dd_deg[Last]) begin
        res[i] = '0;
      end else if (dd_neg[Last][i]) begin
        res[i] = OutWidth'(-qs[i]);
      end else begin
        res[i] = OutWidth'(qs[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dd_v[Last];
    end
    normal_x <= res[0];
    normal_y <= res[1];
    normal_z <= res[2];
    degenerate <= dd_deg[Last];
  end

  // A degenerate result always carries a zero normal.
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("degenerate result with nonzero normal");

  // The square root of a nonzero normalized sum has one of its top two bits set.
  a_len_top: assert property (@(posedge clk) disable iff (rst)
    dv_v && !dv_deg |-> dv_len[LenWidth-1] || dv_len[LenWidth-2])
    else $error("normalized length out of range");

  // The x component never exceeds one in magnitude.
  a_unit: assert property (@(posedge clk) disable iff (rst)
    done && !degenerate |-> (normal_x <= 16'sd16384) && (normal_x >= -16'sd16384))
    else $error("normal component out of range");

  // The block never refuses an item.
  a_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

endmodule
